// File: src/sbq_pkg.sv
// ============================================================================
// sbq_pkg: shared constants for the steering button qualifier
// Button codes, configuration register indexes and stream field widths.
// ============================================================================
package sbq_pkg;

    // Button codes (codes five to seven are legal but drive nothing)
    localparam int unsigned CODE_W = 3;
    localparam logic [CODE_W-1:0] CODE_NONE    = 3'd0;
    localparam logic [CODE_W-1:0] CODE_UPSET   = 3'd1;
    localparam logic [CODE_W-1:0] CODE_DOWNRES = 3'd2;
    localparam logic [CODE_W-1:0] CODE_CANCEL  = 3'd3;
    localparam logic [CODE_W-1:0] CODE_MAIN    = 3'd4;

    // Configuration port
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_MS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAIN_HOLD_MS = 2'd1;
    localparam logic [CFG_DATA_W-1:0]  DEBOUNCE_RESET   = 16'd60;
    localparam logic [CFG_DATA_W-1:0]  MAIN_HOLD_RESET  = 16'd1000;

    // Stream payload widths
    localparam int unsigned STAMP_W  = 32;
    localparam int unsigned IN_DW    = 40;   // 3 + 1 + 32 bits, padded to bytes
    localparam int unsigned OUT_DW   = 8;    // 3 + 4 bits, padded to a byte

endpackage : sbq_pkg

// File: src/steering_button_qualifier_top.sv
// ============================================================================
// steering_button_qualifier_top: debounced steering button with one-shot main
// Debounces a sampled button code with wrap-safe millisecond compares and
// drives momentary and one-shot outputs, cleared while the brake is active.
// ============================================================================
// Usage:
//   Input beats on s_axis_* carry one sample each: button code, brake level
//   and a millisecond time stamp. Every accepted beat yields exactly one
//   output beat on m_axis_* with the debounced code and the output levels.
//   An accepted beat is loaded into the input register, then moves through
//   the qualifier logic into the output register once that register has
//   room. Throughput is one beat per cycle while the receiver does not
//   stall; the rate is set by the state update between the two registers.
//   When the receiver stalls, the output register holds its beat and the
//   input register takes one more beat, after which s_axis_tready drops.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the
//   clock edge; index 0 is debounce_ms, index 1 is main_hold_ms, others are
//   ignored. Write only while no beat is in flight.
//   Reset clears all qualifier state and the valid flags of both pipeline
//   registers, and loads debounce_ms = 60 and main_hold_ms = 1000.
// ============================================================================
module steering_button_qualifier_top #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: [2:0] button_code, [3] brake_active, [35:4] now_ms, [39:36] zero
    input  logic [sbq_pkg::IN_DW-1:0]       s_axis_tdata,
    // Output stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: [2:0] stable_button, [3] up_set_out, [4] down_res_out,
    //        [5] cancel_out, [6] main_out, [7] zero
    output logic [sbq_pkg::OUT_DW-1:0]      m_axis_tdata,
    // Configuration write port
    input  logic                            cfg_we,
    input  logic [sbq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sbq_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sbq_pkg::*;

    localparam int unsigned TW = TIME_WIDTH;

    // Configuration registers
    logic [CFG_DATA_W-1:0] debounce_reg;
    logic [CFG_DATA_W-1:0] hold_reg;

    // Input register
    logic              in_valid_reg;
    logic [CODE_W-1:0] in_code_reg;
    logic              in_brake_reg;
    logic [STAMP_W-1:0] in_stamp_reg;

    // Qualifier state
    logic [CODE_W-1:0] cand_code_reg,  cand_code_next;
    logic [CODE_W-1:0] stable_reg,     stable_next;
    logic [TW-1:0]     cand_start_reg, cand_start_next;
    logic              up_next;
    logic              down_next;
    logic              cancel_next;
    logic              was_down_reg,   was_down_next;
    logic              pulse_reg,      pulse_next;
    logic [TW-1:0]     pulse_end_reg,  pulse_end_next;

    // Output register
    logic              out_valid_reg;
    logic [OUT_DW-1:0] out_data_reg;

    // Datapath helpers
    logic              advance;
    logic [TW+STAMP_W-1:0]  stamp_wide;
    logic [TW+CFG_DATA_W-1:0] deb_wide;
    logic [TW+CFG_DATA_W-1:0] hold_wide;
    logic [TW-1:0]     now_t;
    logic [TW-1:0]     deb_t;
    logic [TW-1:0]     hold_t;
    logic [TW-1:0]     deb_diff;
    logic [TW-1:0]     pulse_diff;
    logic              main_down;
    logic              pulse_start;
    logic              pulse_on;

    // Handshake: the item moves from input to output register when there is room
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Fit the time stamp and the millisecond settings to the time width
    assign stamp_wide = {{TW{1'b0}}, in_stamp_reg};
    assign deb_wide   = {{TW{1'b0}}, debounce_reg};
    assign hold_wide  = {{TW{1'b0}}, hold_reg};
    assign now_t      = stamp_wide[TW-1:0];
    assign deb_t      = deb_wide[TW-1:0];
    assign hold_t     = hold_wide[TW-1:0];

    // Debounce: a new code restarts the candidate, a held one becomes stable
    assign deb_diff = now_t - (cand_start_reg + deb_t);

    always_comb
    begin
        cand_code_next  = cand_code_reg;
        cand_start_next = cand_start_reg;
        stable_next     = stable_reg;
        if (in_code_reg != cand_code_reg)
        begin
            cand_code_next  = in_code_reg;
            cand_start_next = now_t;
        end
        else if ((stable_reg != cand_code_reg) && !deb_diff[TW-1])
        begin
            stable_next = cand_code_reg;
        end
    end

    // Output levels and main one-shot
    assign main_down      = (stable_next == CODE_MAIN);
    assign pulse_start    = main_down && !was_down_reg && !pulse_reg;
    assign pulse_end_next = (pulse_start && !in_brake_reg) ? (now_t + hold_t)
                                                           : pulse_end_reg;
    assign pulse_on       = pulse_reg || pulse_start;
    assign pulse_diff     = now_t - pulse_end_next;

    always_comb
    begin
        if (in_brake_reg)
        begin
            up_next       = 1'b0;
            down_next     = 1'b0;
            cancel_next   = 1'b0;
            was_down_next = 1'b0;
            pulse_next    = 1'b0;
        end
        else
        begin
            up_next       = (stable_next == CODE_UPSET);
            down_next     = (stable_next == CODE_DOWNRES);
            cancel_next   = (stable_next == CODE_CANCEL);
            was_down_next = main_down;
            // a pulse ends once now reaches its end mark, possibly in the same beat
            pulse_next    = pulse_on && pulse_diff[TW-1];
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
            hold_reg     <= MAIN_HOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEBOUNCE_MS:  debounce_reg <= cfg_data;
                CFG_MAIN_HOLD_MS: hold_reg     <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_code_reg  <= s_axis_tdata[CODE_W-1:0];
            in_brake_reg <= s_axis_tdata[CODE_W];
            in_stamp_reg <= s_axis_tdata[CODE_W+STAMP_W:CODE_W+1];
        end
    end

    // Qualifier state, committed once per beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_code_reg  <= CODE_NONE;
            stable_reg     <= CODE_NONE;
            cand_start_reg <= '0;
            was_down_reg   <= 1'b0;
            pulse_reg      <= 1'b0;
            pulse_end_reg  <= '0;
        end
        else if (advance)
        begin
            cand_code_reg  <= cand_code_next;
            stable_reg     <= stable_next;
            cand_start_reg <= cand_start_next;
            was_down_reg   <= was_down_next;
            pulse_reg      <= pulse_next;
            pulse_end_reg  <= pulse_end_next;
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || m_axis_tready)
            out_valid_reg <= advance;
    end

    // Output register payload; the momentary levels live only in this beat
    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= {1'b0, pulse_next, cancel_next, down_next, up_next,
                             stable_next};
    end

endmodule : steering_button_qualifier_top
